// File: design/hdr_pixel_quantize_intensity_scale_unit_assert.svh
// assertion macros for the hdr pixel quantizer
`ifndef HDR_PIXEL_QUANTIZE_INTENSITY_SCALE_UNIT_ASSERT_SVH
`define HDR_PIXEL_QUANTIZE_INTENSITY_SCALE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define HPQIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define HPQIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hpqis_pkg.sv
package hpqis_pkg;

  localparam int CH_W    = 32;
  localparam int Q_W     = 8;
  localparam int SCALE_W = 32;
  localparam int CNT_W   = 5;

  localparam logic [Q_W-1:0] ALPHA_VAL = 8'hFF;
  localparam logic [Q_W-1:0] Q_MAX     = 8'hFF;

  // sequencer codes
  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_QUANT  = 3'd1;
  localparam logic [ST_W-1:0] ST_CLAMP  = 3'd2;
  localparam logic [ST_W-1:0] ST_EXCESS = 3'd3;
  localparam logic [ST_W-1:0] ST_SUMN   = 3'd4;
  localparam logic [ST_W-1:0] ST_OVF    = 3'd5;
  localparam logic [ST_W-1:0] ST_DIV    = 3'd6;
  localparam logic [ST_W-1:0] ST_DONE   = 3'd7;

  localparam logic [CNT_W-1:0] QUANT_LAST = 5'd2;
  localparam logic [CNT_W-1:0] DIV_LAST   = 5'd31;

endpackage

// File: design/hdr_pixel_quantize_intensity_scale_unit.sv
// HDR pixel quantizer with image intensity compensation. Each input word is one pixel
// (three unsigned fixed-point channels with FRAC_BITS fraction bits, tlast on the final
// pixel of the image); each output word holds the channels quantized to 8 bits as
// min(floor(c*255), 255), alpha 255, and the intensity scale. The scale is
// (clamped + excess) / clamped over the whole image, saturated to all ones, or 1.0 when
// the clamped sum is at most 1.0; it and the over-range flag in tuser are meaningful on
// the word with tlast set, other words carry 1.0 and 0. The sums, quantize products and
// division steps run through one shared add/subtract unit under a small sequencer: an
// ordinary pixel's result word is loaded after three quantize steps and two sum updates,
// and the next pixel is taken only once the sequencer is back in idle, so a new pixel is
// not taken before the last one's word is loaded. The last pixel adds the sum and the
// overflow test, plus a 32-step restoring division when the clamped sum is above 1.0 and
// the scale does not saturate. in_tready is high only while the sequencer is idle; a
// finished word sits in the output register, so the next pixel is taken while it waits,
// but a word that finds the register still full holds the sequencer in its load step
// until out_tready frees it.
`include "hdr_pixel_quantize_intensity_scale_unit_assert.svh"

module hdr_pixel_quantize_intensity_scale_unit #(
  parameter int PIXEL_COUNT_BITS = 22,
  parameter int FRAC_BITS        = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // red_in, green_in, blue_in
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // red_out, green_out, blue_out, alpha_out, intensity_scale
  output logic        out_tlast,  // scale_ready
  output logic        out_tuser   // beyond_display
);

  localparam int CW = FRAC_BITS + PIXEL_COUNT_BITS + 1;
  localparam int EW = 32 + PIXEL_COUNT_BITS;
  localparam int NW = EW + 1;
  // wide enough for the sums and for c << 8 in the quantize step
  localparam int UW = (NW + 1 > hpqis_pkg::CH_W + 8) ? NW + 1 : hpqis_pkg::CH_W + 8;
  localparam int SH = 32 - FRAC_BITS;

  localparam logic [hpqis_pkg::CH_W-1:0]    ONE_CH = hpqis_pkg::CH_W'(1) << FRAC_BITS;
  localparam logic [CW-1:0]                 ONE_CL = CW'(1) << FRAC_BITS;
  localparam logic [hpqis_pkg::SCALE_W-1:0] ONE_SC = hpqis_pkg::SCALE_W'(1) << FRAC_BITS;

  logic [hpqis_pkg::ST_W-1:0]    state_r;
  logic [hpqis_pkg::CNT_W-1:0]   cnt_r;
  logic [hpqis_pkg::CH_W-1:0]    ch_r [3];
  logic                          last_r;
  logic [hpqis_pkg::CH_W-1:0]    m_r;
  logic [3*hpqis_pkg::Q_W-1:0]   q_r;
  logic [CW-1:0]                 clamped_r;
  logic [EW-1:0]                 excess_r;
  logic                          seen_r;
  logic [NW-1:0]                 num_r;
  logic [CW-1:0]                 rem_r;
  logic [31:0]                   dlow_r;
  logic [hpqis_pkg::SCALE_W-1:0] quot_r;
  logic [hpqis_pkg::SCALE_W-1:0] scale_r;
  logic                          out_valid_r;
  logic [63:0]                   out_data_r;
  logic                          out_last_r;
  logic                          out_user_r;

  // shared add/subtract unit
  logic [UW-1:0] ua, ub;
  logic          usub;
  logic [UW:0]   usum;

  logic [hpqis_pkg::CH_W-1:0] mc, mex;
  logic                       m_over;
  logic [39:0]                prod_hi;
  logic [hpqis_pkg::Q_W-1:0]  q_nxt;
  logic [hpqis_pkg::CH_W-1:0] m_nxt;
  logic [CW-1:0]              clamped_nxt, rem_nxt;
  logic [EW-1:0]              excess_nxt;
  logic                       out_ld;
  logic                       sums_zero;

  assign m_over = (m_r > ONE_CH);
  assign mc     = m_over ? ONE_CH : m_r;
  assign mex    = m_over ? (m_r - ONE_CH) : '0;

  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    case (state_r)
      hpqis_pkg::ST_QUANT: begin
        // c*255 as (c << 8) - c
        ua   = UW'({ch_r[0], 8'h00});
        ub   = UW'(ch_r[0]);
        usub = 1'b1;
      end
      hpqis_pkg::ST_CLAMP: begin
        ua = UW'(clamped_r);
        ub = UW'(mc);
      end
      hpqis_pkg::ST_EXCESS: begin
        ua = UW'(excess_r);
        ub = UW'(mex);
      end
      hpqis_pkg::ST_SUMN: begin
        ua = UW'(excess_r);
        ub = UW'(clamped_r);
      end
      hpqis_pkg::ST_OVF: begin
        // whole part overflows when num >= clamped << (32 - frac)
        ua   = UW'(num_r);
        ub   = UW'(clamped_r) << SH;
        usub = 1'b1;
      end
      hpqis_pkg::ST_DIV: begin
        ua   = UW'({rem_r, dlow_r[31]});
        ub   = UW'(clamped_r);
        usub = 1'b1;
      end
      default: begin
        ua   = '0;
        ub   = '0;
        usub = 1'b0;
      end
    endcase
  end

  assign usum = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + (UW+1)'(usub);

  assign prod_hi = usum[39:0] >> FRAC_BITS;
  assign q_nxt   = (|prod_hi[39:8]) ? hpqis_pkg::Q_MAX : prod_hi[7:0];

  always_comb begin
    m_nxt = m_r;
    if (cnt_r == '0 || ch_r[0] > m_r) begin
      m_nxt = ch_r[0];
    end
  end

  // sums saturate at all ones instead of wrapping
  assign clamped_nxt = usum[CW] ? '1 : usum[CW-1:0];
  assign excess_nxt  = usum[EW] ? '1 : usum[EW-1:0];
  // carry out set means partial remainder reached the divisor
  assign rem_nxt     = usum[UW] ? usum[CW-1:0] : {rem_r[CW-2:0], dlow_r[31]};

  assign out_ld    = (state_r == hpqis_pkg::ST_DONE) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == hpqis_pkg::ST_IDLE);

  // control and image sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hpqis_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      clamped_r   <= '0;
      excess_r    <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        hpqis_pkg::ST_IDLE: begin
          cnt_r <= '0;
          if (in_tvalid) begin
            state_r <= hpqis_pkg::ST_QUANT;
          end
        end
        hpqis_pkg::ST_QUANT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == hpqis_pkg::QUANT_LAST) begin
            state_r <= hpqis_pkg::ST_CLAMP;
          end
        end
        hpqis_pkg::ST_CLAMP: begin
          clamped_r <= clamped_nxt;
          seen_r    <= seen_r | m_over;
          state_r   <= hpqis_pkg::ST_EXCESS;
        end
        hpqis_pkg::ST_EXCESS: begin
          excess_r <= excess_nxt;
          state_r  <= last_r ? hpqis_pkg::ST_SUMN : hpqis_pkg::ST_DONE;
        end
        hpqis_pkg::ST_SUMN: begin
          state_r <= hpqis_pkg::ST_OVF;
        end
        hpqis_pkg::ST_OVF: begin
          cnt_r <= '0;
          if (clamped_r <= ONE_CL || usum[UW]) begin
            state_r <= hpqis_pkg::ST_DONE;
          end else begin
            state_r <= hpqis_pkg::ST_DIV;
          end
        end
        hpqis_pkg::ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == hpqis_pkg::DIV_LAST) begin
            state_r <= hpqis_pkg::ST_DONE;
          end
        end
        hpqis_pkg::ST_DONE: begin
          if (out_ld) begin
            if (last_r) begin
              clamped_r <= '0;
              excess_r  <= '0;
              seen_r    <= 1'b0;
            end
            state_r <= hpqis_pkg::ST_IDLE;
          end
        end
        default: begin
          state_r <= hpqis_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      hpqis_pkg::ST_IDLE: begin
        ch_r[0] <= in_tdata[31:0];
        ch_r[1] <= in_tdata[63:32];
        ch_r[2] <= in_tdata[95:64];
        last_r  <= in_tlast;
      end
      hpqis_pkg::ST_QUANT: begin
        // rotate channels so the unit always sees ch_r[0]
        ch_r[0] <= ch_r[1];
        ch_r[1] <= ch_r[2];
        ch_r[2] <= ch_r[0];
        m_r     <= m_nxt;
        q_r     <= {q_nxt, q_r[3*hpqis_pkg::Q_W-1:hpqis_pkg::Q_W]};
      end
      hpqis_pkg::ST_EXCESS: begin
        scale_r <= ONE_SC;
      end
      hpqis_pkg::ST_SUMN: begin
        num_r <= usum[NW-1:0];
      end
      hpqis_pkg::ST_OVF: begin
        if (clamped_r <= ONE_CL) begin
          scale_r <= ONE_SC;
        end else if (usum[UW]) begin
          scale_r <= '1;
        end
        rem_r  <= CW'(num_r >> SH);
        dlow_r <= {num_r[SH-1:0], FRAC_BITS'(0)};
      end
      hpqis_pkg::ST_DIV: begin
        rem_r  <= rem_nxt;
        dlow_r <= {dlow_r[30:0], 1'b0};
        quot_r <= {quot_r[30:0], usum[UW]};
        if (cnt_r == hpqis_pkg::DIV_LAST) begin
          scale_r <= {quot_r[30:0], usum[UW]};
        end
      end
      hpqis_pkg::ST_DONE: begin
        if (out_ld) begin
          out_data_r <= {scale_r, hpqis_pkg::ALPHA_VAL, q_r};
          out_last_r <= last_r;
          out_user_r <= last_r & seen_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  assign sums_zero = (clamped_r == '0) && (excess_r == '0) && !seen_r;

  `HPQIS_ASSERT_NOW(a_flag_only_on_last, out_tvalid && out_tuser, out_tlast, "flag without last")
  `HPQIS_ASSERT_NOW(a_neutral_scale, out_tvalid && !out_tlast, out_tdata[63:32] == ONE_SC, "not 1.0")
  `HPQIS_ASSERT_NOW(a_scale_floor, out_tvalid && out_tlast, out_tdata[63:32] >= ONE_SC, "below 1.0")
  `HPQIS_ASSERT_NEXT(a_sums_cleared, out_ld && last_r, sums_zero, "sums not cleared after last")

endmodule
